FILE: hdl/mcsf_pkg.sv
// Shared types and constants for the midpoint circle span fill core.
// Used by every module under hdl; depends on nothing.
package mcsf_pkg;

   localparam int CENTER_BITS     = 10;
   localparam int RADIUS_BITS     = 6;
   localparam int OUT_BITS        = 12;
   localparam int REQ_TDATA_BITS  = 32;
   localparam int RSP_TDATA_BITS  = 8 * OUT_BITS;
   localparam int MAX_RADIUS_DEF  = 63;
   localparam int COORD_BITS_DEF  = 10;
   localparam int MAX_RESULTS     = 46;
   localparam int COUNT_BITS      = 6;
   localparam int STEP_BITS       = RADIUS_BITS + 1;
   localparam int DEC_BITS        = 12;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
   localparam logic [DEC_BITS-1:0] DEC_INC_HOLD = DEC_BITS'(6);
   localparam logic [DEC_BITS-1:0] DEC_INC_STEP = DEC_BITS'(10);

   typedef struct packed {
      logic [CENTER_BITS-1:0] center_x;
      logic [CENTER_BITS-1:0] center_y;
      logic [RADIUS_BITS-1:0] radius;
   } circle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] lower_mid_row;
      logic signed [OUT_BITS-1:0] upper_mid_row;
      logic signed [OUT_BITS-1:0] outer_right;
      logic signed [OUT_BITS-1:0] outer_left;
      logic signed [OUT_BITS-1:0] bottom_row;
      logic signed [OUT_BITS-1:0] top_row;
      logic signed [OUT_BITS-1:0] inner_right;
      logic signed [OUT_BITS-1:0] inner_left;
   } span_type;

   typedef enum logic {
      ENG_IDLE,
      ENG_RUN
   } eng_state_type;

endpackage

FILE: hdl/mcsf_front.sv
// Request stage: registers one circle, masks the center and caps the radius,
// then pushes it into the circle queue. Depends on mcsf_pkg.
module mcsf_front #(
   parameter int MAX_RADIUS = mcsf_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = mcsf_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mcsf_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  mcsf_pkg::queue_stat_type            queue_stat,
   output logic                                push,
   output mcsf_pkg::circle_type                push_circle
);
   import mcsf_pkg::*;

   localparam int RadCapInt = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
   localparam logic [RADIUS_BITS-1:0] RadCap = RADIUS_BITS'(RadCapInt);
   localparam logic [CENTER_BITS-1:0] CoordMask = (COORD_BITS >= CENTER_BITS) ?
      {CENTER_BITS{1'b1}} : CENTER_BITS'((1 << COORD_BITS) - 1);

   logic       hold_valid_ff, hold_valid_in;
   circle_type hold_ff, hold_in;
   circle_type raw;
   logic       take;

   assign raw.center_x = req_tdata[CENTER_BITS-1:0];
   assign raw.center_y = req_tdata[2*CENTER_BITS-1:CENTER_BITS];
   assign raw.radius   = req_tdata[2*CENTER_BITS+RADIUS_BITS-1:2*CENTER_BITS];

   assign push        = hold_valid_ff && !queue_stat.full;
   assign req_tready  = !hold_valid_ff || push;
   assign take        = req_tvalid && req_tready;
   assign push_circle = hold_ff;

   always_comb begin
      hold_in.center_x = raw.center_x & CoordMask;
      hold_in.center_y = raw.center_y & CoordMask;
      hold_in.radius   = (raw.radius > RadCap) ? RadCap : raw.radius;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= hold_in;
      end
   end

endmodule

FILE: hdl/mcsf_queue.sv
// Short circle queue between the request stage and the span engine.
// Depends on mcsf_pkg.
module mcsf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mcsf_pkg::circle_type       push_circle,
   input  logic                       pop,
   output mcsf_pkg::circle_type       head,
   output mcsf_pkg::queue_stat_type   stat
);
   import mcsf_pkg::*;

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);
   localparam logic [PtrBits:0]   FullCnt = (PtrBits + 1)'(QUEUE_DEPTH);

   circle_type         slot_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign stat.full  = (cnt_ff == FullCnt);
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_circle;
      end
   end

endmodule

FILE: hdl/mcsf_engine.sv
// Span engine: runs the midpoint circle steps for one queued circle and
// drives the response register. Depends on mcsf_pkg.
module mcsf_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  mcsf_pkg::queue_stat_type            queue_stat,
   input  mcsf_pkg::circle_type                head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mcsf_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast
);
   import mcsf_pkg::*;

   localparam logic [COUNT_BITS-1:0] LastCount = COUNT_BITS'(MAX_RESULTS - 1);

   eng_state_type          state_ff, state_in;
   logic [CENTER_BITS-1:0] cx_ff, cy_ff;
   logic [STEP_BITS-1:0]   x_ff, x_in;
   logic [RADIUS_BITS-1:0] y_ff, y_in;
   logic [DEC_BITS-1:0]    d_ff, d_in;
   logic [COUNT_BITS-1:0]  n_ff;
   logic                   out_valid_ff, out_valid_in;
   span_type               span_ff, span_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_free, load, step_last;
   logic [DEC_BITS-1:0]    x_ext, y_ext;

   assign out_free = !out_valid_ff || rsp_tready;
   assign x_ext    = DEC_BITS'(x_ff);
   assign y_ext    = DEC_BITS'(y_ff);

   always_comb begin
      x_in = x_ff + 1'b1;
      if (d_ff[DEC_BITS-1]) begin
         d_in = d_ff + (x_ext << 2) + DEC_INC_HOLD;
         y_in = y_ff;
      end else begin
         d_in = d_ff + ((x_ext - y_ext) << 2) + DEC_INC_STEP;
         y_in = y_ff - 1'b1;
      end
      step_last = (d_ff[DEC_BITS-1] ? (STEP_BITS'(y_ff) < x_in) :
                   (STEP_BITS'(y_ff) < x_in + 1'b1)) || (n_ff == LastCount);
   end

   always_comb begin
      span_in.inner_left    = OUT_BITS'(cx_ff) - OUT_BITS'(x_ff);
      span_in.inner_right   = OUT_BITS'(cx_ff) + OUT_BITS'(x_ff);
      span_in.top_row       = OUT_BITS'(cy_ff) - OUT_BITS'(y_ff);
      span_in.bottom_row    = OUT_BITS'(cy_ff) + OUT_BITS'(y_ff);
      span_in.outer_left    = OUT_BITS'(cx_ff) - OUT_BITS'(y_ff);
      span_in.outer_right   = OUT_BITS'(cx_ff) + OUT_BITS'(y_ff);
      span_in.upper_mid_row = OUT_BITS'(cy_ff) - OUT_BITS'(x_ff);
      span_in.lower_mid_row = OUT_BITS'(cy_ff) + OUT_BITS'(x_ff);
      out_last_in           = step_last;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (!queue_stat.empty) begin
               state_in = ENG_RUN;
            end
         end
         ENG_RUN: begin
            if (out_free && step_last) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         ENG_IDLE: pop  = !queue_stat.empty;
         ENG_RUN:  load = out_free;
         default: begin
            pop  = 1'b0;
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cx_ff <= head.center_x;
         cy_ff <= head.center_y;
         x_ff  <= '0;
         y_ff  <= head.radius;
         d_ff  <= DEC_INIT - (DEC_BITS'(head.radius) << 1);
         n_ff  <= '0;
      end else if (load) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         d_ff  <= d_in;
         n_ff  <= n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         span_ff     <= span_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = span_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: hdl/midpoint_circle_span_fill_core.sv
// Midpoint circle span fill, top level: request stage, circle queue and
// span engine. Depends on mcsf_pkg, mcsf_front, mcsf_queue and mcsf_engine.
//
// Each request is one circle; the core answers with one span group per
// midpoint step, about r/sqrt(2)+1 groups for radius r (at most 46), with
// tlast on the final group. The span engine holds one step datapath and
// emits one group per clock while the response side takes them, and
// between circles it passes through its idle state to pop the next circle
// from the queue. Up to two circles wait in the queue and one in the
// request register, so requests keep flowing while a circle is being drawn.
module midpoint_circle_span_fill_core #(
   parameter int MAX_RADIUS = mcsf_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = mcsf_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // center_x [9:0], center_y [19:10], radius [25:20], zero [31:26]
   input  logic [mcsf_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // inner_left, inner_right, top_row, bottom_row, outer_left,
   // outer_right, upper_mid_row, lower_mid_row: 12 bits each from bit 0 up
   output logic [mcsf_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast
);
   import mcsf_pkg::*;

   queue_stat_type queue_stat;
   circle_type     push_circle, head;
   logic           push, pop;

   mcsf_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_stat  (queue_stat),
      .push        (push),
      .push_circle (push_circle)
   );

   mcsf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_circle (push_circle),
      .pop         (pop),
      .head        (head),
      .stat        (queue_stat)
   );

   mcsf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .queue_stat (queue_stat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sim/midpoint_circle_span_fill_core_test.sv
// Self-checking testbench for midpoint_circle_span_fill_core: circle requests in,
// span groups out, checked against an in-bench midpoint circle predictor.
// Depends on mcsf_pkg and the core RTL under hdl.
`timescale 1ns / 1ps

module midpoint_circle_span_fill_core_test;
   import mcsf_pkg::*;

   localparam int N_DIRECTED  = 14;
   localparam int N_RANDOM    = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int QUIET_FIRST = N_DIRECTED + 40;
   localparam int QUIET_LAST  = N_DIRECTED + 65;

   typedef struct packed {
      logic     last;
      span_type spans;
   } span_group_type;

   typedef struct packed {
      logic [CENTER_BITS-1:0] cx;
      logic [CENTER_BITS-1:0] cy;
      logic [RADIUS_BITS-1:0] r;
      logic                   typed;
      span_type               spans;
   } circle_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;

   span_group_type circle_spans [$];
   circle_row_type directed_circles [N_DIRECTED];
   string          span_names [8] = '{"inner_left", "inner_right", "top_row", "bottom_row",
                                      "outer_left", "outer_right", "upper_mid_row",
                                      "lower_mid_row"};
   int             mismatches = 0;
   int             accepted_requests = 0;
   int             cycle_count = 0;
   int             hold_left = 0;
   logic           hold_done = 1'b0;
   logic           quiet;

   midpoint_circle_span_fill_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign quiet = (accepted_requests >= QUIET_FIRST) && (accepted_requests < QUIET_LAST);

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic span_type spans_of(input int il, input int ir, input int rt,
                                         input int rb, input int ol, input int oright,
                                         input int ru, input int rl);
      span_type s;
      s.inner_left    = OUT_BITS'(il);
      s.inner_right   = OUT_BITS'(ir);
      s.top_row       = OUT_BITS'(rt);
      s.bottom_row    = OUT_BITS'(rb);
      s.outer_left    = OUT_BITS'(ol);
      s.outer_right   = OUT_BITS'(oright);
      s.upper_mid_row = OUT_BITS'(ru);
      s.lower_mid_row = OUT_BITS'(rl);
      return s;
   endfunction

   // midpoint walk over the first octant, one span group per step
   task automatic draw_circle(input logic [CENTER_BITS-1:0] cx,
                              input logic [CENTER_BITS-1:0] cy,
                              input logic [RADIUS_BITS-1:0] r);
      int             x;
      int             y;
      int             d;
      int             n;
      int             rad;
      span_group_type g;
      rad = (int'(r) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(r);
      x = 0;
      y = rad;
      d = 3 - 2 * rad;
      n = 0;
      while (y >= x && n < MAX_RESULTS) begin
         g.spans = spans_of(int'(cx) - x, int'(cx) + x, int'(cy) - y, int'(cy) + y,
                            int'(cx) - y, int'(cx) + y, int'(cy) - x, int'(cy) + x);
         if (d < 0) begin
            d = d + 4 * x + 6;
         end else begin
            d = d + 4 * (x - y) + 10;
            y = y - 1;
         end
         x = x + 1;
         n = n + 1;
         g.last = (y < x) || (n == MAX_RESULTS);
         circle_spans = {circle_spans, g};
      end
   endtask

   // offer one request, with an occasional gap, and hold it until taken
   task automatic offer_circle(input logic [CENTER_BITS-1:0] cx,
                               input logic [CENTER_BITS-1:0] cy,
                               input logic [RADIUS_BITS-1:0] r);
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted_requests <= accepted_requests + 1;
   endtask

   task automatic drain_spans;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (circle_spans.size() != 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("midpoint_circle_span_fill_core_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      span_group_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (circle_spans.size() == 0) begin
            report_mismatch($sformatf("span group %h with no circle pending", rsp_tdata));
         end else begin
            want = circle_spans.pop_front();
            for (int f = 0; f < 8; f++) begin
               if (rsp_tdata[f*OUT_BITS +: OUT_BITS] !== want.spans[f*OUT_BITS +: OUT_BITS])
                  report_mismatch($sformatf("%s got %0d want %0d", span_names[f],
                     $signed(rsp_tdata[f*OUT_BITS +: OUT_BITS]),
                     $signed(want.spans[f*OUT_BITS +: OUT_BITS])));
            end
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast got %b want %b", rsp_tlast, want.last));
         end
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && accepted_requests >= N_DIRECTED + 20) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 7);
      end
   end

   initial begin
      int                     k;
      int                     pick;
      logic [CENTER_BITS-1:0] circle_x;
      logic [CENTER_BITS-1:0] circle_y;
      logic [RADIUS_BITS-1:0] circle_r;
      span_group_type         g;

      directed_circles[0]  = '{10'd0, 10'd0, 6'd0, 1'b1, spans_of(0, 0, 0, 0, 0, 0, 0, 0)};
      directed_circles[1]  = '{10'd1023, 10'd1023, 6'd0, 1'b1,
                               spans_of(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023)};
      directed_circles[2]  = '{10'd512, 10'd512, 6'd1, 1'b1,
                               spans_of(512, 512, 511, 513, 511, 513, 512, 512)};
      directed_circles[3]  = '{10'd0, 10'd0, 6'd1, 1'b1, spans_of(0, 0, -1, 1, -1, 1, 0, 0)};
      directed_circles[4]  = '{10'd0, 10'd0, 6'd63, 1'b0, '0};
      directed_circles[5]  = '{10'd1023, 10'd1023, 6'd63, 1'b0, '0};
      directed_circles[6]  = '{10'd0, 10'd1023, 6'd63, 1'b0, '0};
      directed_circles[7]  = '{10'd1023, 10'd0, 6'd63, 1'b0, '0};
      directed_circles[8]  = '{10'd5, 10'd7, 6'd2, 1'b0, '0};
      directed_circles[9]  = '{10'h2AA, 10'h155, 6'h2A, 1'b0, '0};
      directed_circles[10] = '{10'h155, 10'h2AA, 6'h15, 1'b0, '0};
      directed_circles[11] = '{10'd100, 10'd900, 6'd3, 1'b0, '0};
      directed_circles[12] = '{10'd31, 10'd62, 6'd31, 1'b0, '0};
      directed_circles[13] = '{10'd700, 10'd300, 6'd62, 1'b0, '0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIRECTED; k++) begin
         offer_circle(directed_circles[k].cx, directed_circles[k].cy, directed_circles[k].r);
         if (directed_circles[k].typed) begin
            g.spans = directed_circles[k].spans;
            g.last  = 1'b1;
            circle_spans = {circle_spans, g};
         end else begin
            draw_circle(directed_circles[k].cx, directed_circles[k].cy, directed_circles[k].r);
         end
      end
      drain_spans();

      for (k = 0; k < N_RANDOM; k++) begin
         if (k == 70)
            drain_spans();
         pick     = $urandom_range(0, 99);
         circle_r = (pick < 65) ? RADIUS_BITS'($urandom_range(0, 15)) :
                    (pick < 90) ? RADIUS_BITS'($urandom_range(16, 62)) : 6'd63;
         pick     = $urandom_range(0, 19);
         circle_x = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
                    CENTER_BITS'($urandom_range(0, 1023));
         circle_y = (pick == 2) ? 10'd0 : (pick == 3) ? 10'd1023 :
                    CENTER_BITS'($urandom_range(0, 1023));
         offer_circle(circle_x, circle_y, circle_r);
         draw_circle(circle_x, circle_y, circle_r);
      end
      drain_spans();
      repeat (60) @(posedge clock);

      if (mismatches == 0)
         $display("midpoint_circle_span_fill_core_test OK");
      else
         $display("midpoint_circle_span_fill_core_test NOT OK");
      $finish;
   end

endmodule

FILE: midpoint_circle_span_fill_core.f
hdl/mcsf_pkg.sv
hdl/mcsf_front.sv
hdl/mcsf_queue.sv
hdl/mcsf_engine.sv
hdl/midpoint_circle_span_fill_core.sv
sim/midpoint_circle_span_fill_core_test.sv
